@@ hw/rtl/intel_hex_record_writer_core_assert.svh @@
// Assertion macros shared by the checker of intel_hex_record_writer_core.
// Plain text macros; no dependencies.
`ifndef INTEL_HEX_RECORD_WRITER_CORE_ASSERT_SVH
`define INTEL_HEX_RECORD_WRITER_CORE_ASSERT_SVH

// same-cycle implication
`define IHEXW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ihexw assertion failed");

// next-cycle implication
`define IHEXW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ihexw assertion failed");

`endif

@@ hw/rtl/ihexw_pkg.sv @@
// Shared types, constants and helper functions of the Intel HEX record writer.
// No dependencies.
package ihexw_pkg;

    localparam int RECORD_BYTES = 16;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

    localparam int CFG_IDX_W    = 2;
    localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_ADDRESS   = 2'd1;

    // character positions of the back-end sequencer
    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] POS_HDR      = 5'd0;
    localparam logic [POS_W-1:0] POS_DATA     = 5'd9;
    localparam logic [POS_W-1:0] POS_DATA_LO  = 5'd10;
    localparam logic [POS_W-1:0] POS_SUM      = 5'd11;
    localparam logic [POS_W-1:0] POS_NEWLINE  = 5'd13;
    localparam logic [POS_W-1:0] POS_EOF      = 5'd14;
    localparam logic [POS_W-1:0] POS_EOF_LAST = 5'd25;

    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [7:0] EOF_TEXT [12] = '{
        8'h3A, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30,
        8'h30, 8'h30, 8'h31, 8'h46, 8'h46, 8'h0A
    };

    // one classified item on its way from front to back
    typedef struct packed {
        logic        hdr;
        logic [7:0]  len;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        trl;
        logic [7:0]  chk;
        logic        eof;
    } entry_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
            c = 8'h30 + {4'd0, nib};
        else
            c = 8'h37 + {4'd0, nib};
        return c;
    endfunction

endpackage

@@ hw/rtl/intel_hex_record_writer_core.sv @@
// Intel HEX record writer: turns the bytes of a memory range into record text.
// Top level; instantiates ihexw_front, ihexw_fifo and ihexw_back; uses ihexw_pkg.
//
// Bytes enter on push/full in address order; characters leave on empty/pop,
// one per cycle while pop is high; run_last marks a byte's last character.
// The cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the start
// (index 0) and inclusive end (index 1) addresses; either write restarts the
// dump. cfg_ready is always high; write only while no characters are pending.
// A byte taken into an empty queue goes to the queue memory, then its first
// character to the output register. Each byte yields 2 to 26 characters
// (about 2.75 on average for full 16-byte records); the single character
// output register, one character per cycle while pop is high, sets the rate.
// A four-deep queue lets bytes be taken while earlier ones are still being spelt out.
// Bytes outside the range (start above end, or after the EOF record) are
// accepted and dropped. Reset sets both addresses to 0 and clears all queued
// work. When pop stays low the character holds and full rises once the queue
// fills.
module intel_hex_record_writer_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ihexw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                      cfg_data,
    input  logic                             push,
    output logic                             full,
    input  logic [7:0]                       data_byte,
    output logic                             empty,
    input  logic                             pop,
    output logic [7:0]                       text_char,
    output logic                             run_last
);

    ihexw_pkg::entry_t q_entry, q_head;
    logic              q_wr, q_rd, q_head_valid, q_full;

    assign cfg_ready = 1'b1;
    assign full      = q_full;

    ihexw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (push && !q_full),
        .data_byte (data_byte),
        .q_wr      (q_wr),
        .q_entry   (q_entry)
    );

    ihexw_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (q_wr),
        .wr_entry   (q_entry),
        .full       (q_full),
        .rd         (q_rd),
        .head       (q_head),
        .head_valid (q_head_valid)
    );

    ihexw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_valid (q_head_valid),
        .q_rd       (q_rd),
        .pop        (pop),
        .empty      (empty),
        .text_char  (text_char),
        .run_last   (run_last)
    );

endmodule

@@ hw/rtl/ihexw_fifo.sv @@
// Short queue of classified items between front and back ends.
// Depends on ihexw_pkg.
module ihexw_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  ihexw_pkg::entry_t wr_entry,
    output logic             full,
    input  logic             rd,
    output ihexw_pkg::entry_t head,
    output logic             head_valid
);

    ihexw_pkg::entry_t               mem_reg [ihexw_pkg::FIFO_DEPTH];
    logic [ihexw_pkg::FIFO_AW-1:0]   wptr_reg, wptr_next;
    logic [ihexw_pkg::FIFO_AW-1:0]   rptr_reg, rptr_next;
    logic [ihexw_pkg::FIFO_AW:0]     count_reg, count_next;

    assign full       = (count_reg == (ihexw_pkg::FIFO_AW+1)'(ihexw_pkg::FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (wr)
            wptr_next = wptr_reg + 1'b1;
        if (rd)
            rptr_next = rptr_reg + 1'b1;
        if (wr && !rd)
            count_next = count_reg + 1'b1;
        else if (rd && !wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wptr_reg] <= wr_entry;
    end

endmodule

@@ hw/rtl/ihexw_front.sv @@
// Front end: range registers, record bookkeeping and item classification.
// Depends on ihexw_pkg.
module ihexw_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr,
    input  logic [ihexw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                      cfg_data,
    input  logic                             take,
    input  logic [7:0]                       data_byte,
    output logic                             q_wr,
    output ihexw_pkg::entry_t                q_entry
);

    logic [15:0] start_reg, start_next;
    logic [15:0] end_reg, end_next;
    logic [15:0] addr_reg, addr_next;
    logic [16:0] remaining_reg, remaining_next;
    logic [7:0]  rec_len_reg, rec_len_next;
    logic [7:0]  rec_pos_reg, rec_pos_next;
    logic [7:0]  rec_sum_reg, rec_sum_next;

    logic        live, hdr, trl;
    logic [7:0]  len_new, len_cur, base, sum, pos_inc;

    assign live    = (remaining_reg != 17'd0);
    assign hdr     = (rec_pos_reg == 8'd0);
    assign len_new = (remaining_reg < 17'(ihexw_pkg::RECORD_BYTES)) ?
                     remaining_reg[7:0] : 8'(ihexw_pkg::RECORD_BYTES);
    assign len_cur = hdr ? len_new : rec_len_reg;
    assign base    = hdr ? (len_new + addr_reg[15:8] + addr_reg[7:0]) : rec_sum_reg;
    assign sum     = base + data_byte;
    assign pos_inc = rec_pos_reg + 8'd1;
    assign trl     = (pos_inc >= len_cur);

    assign q_wr          = take && live;
    assign q_entry.hdr   = hdr;
    assign q_entry.len   = len_cur;
    assign q_entry.addr  = addr_reg;
    assign q_entry.data  = data_byte;
    assign q_entry.trl   = trl;
    assign q_entry.chk   = 8'd0 - sum;
    assign q_entry.eof   = (remaining_reg == 17'd1);

    always_comb
    begin
        start_next     = start_reg;
        end_next       = end_reg;
        addr_next      = addr_reg;
        remaining_next = remaining_reg;
        rec_len_next   = rec_len_reg;
        rec_pos_next   = rec_pos_reg;
        rec_sum_next   = rec_sum_reg;

        if (cfg_wr)
        begin
            case (cfg_index)
                ihexw_pkg::REG_START_ADDRESS: start_next = cfg_data;
                ihexw_pkg::REG_END_ADDRESS:   end_next   = cfg_data;
                default: ;
            endcase
            // any write to a real register restarts the dump
            if (cfg_index == ihexw_pkg::REG_START_ADDRESS ||
                cfg_index == ihexw_pkg::REG_END_ADDRESS)
            begin
                addr_next      = start_next;
                remaining_next = (start_next > end_next) ? 17'd0 :
                                 ({1'b0, end_next} - {1'b0, start_next} + 17'd1);
                rec_len_next   = 8'd0;
                rec_pos_next   = 8'd0;
                rec_sum_next   = 8'd0;
            end
        end
        else if (q_wr)
        begin
            addr_next      = addr_reg + 16'd1;
            remaining_next = remaining_reg - 17'd1;
            rec_len_next   = len_cur;
            rec_pos_next   = trl ? 8'd0 : pos_inc;
            rec_sum_next   = trl ? 8'd0 : sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= 16'd0;
            end_reg       <= 16'd0;
            addr_reg      <= 16'd0;
            remaining_reg <= 17'd1;
            rec_len_reg   <= 8'd0;
            rec_pos_reg   <= 8'd0;
            rec_sum_reg   <= 8'd0;
        end
        else
        begin
            start_reg     <= start_next;
            end_reg       <= end_next;
            addr_reg      <= addr_next;
            remaining_reg <= remaining_next;
            rec_len_reg   <= rec_len_next;
            rec_pos_reg   <= rec_pos_next;
            rec_sum_reg   <= rec_sum_next;
        end
    end

endmodule

@@ hw/rtl/ihexw_back.sv @@
// Back end: walks the characters of the queue head into the output register,
// one per cycle while that register is empty or popped. Depends on ihexw_pkg.
module ihexw_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ihexw_pkg::entry_t head,
    input  logic              head_valid,
    output logic              q_rd,
    input  logic              pop,
    output logic              empty,
    output logic [7:0]        text_char,
    output logic              run_last
);

    logic                         active_reg, active_next;
    logic [ihexw_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic                         out_valid_reg, out_valid_next;
    logic [7:0]                   text_reg, text_next;
    logic                         last_reg, last_next;

    logic [ihexw_pkg::POS_W-1:0]  cur_pos, seq_pos;
    logic                         step, done;
    logic [7:0]                   chr;
    logic [3:0]                   eof_idx;

    assign cur_pos = active_reg ? pos_reg :
                     (head.hdr ? ihexw_pkg::POS_HDR : ihexw_pkg::POS_DATA);
    assign step    = head_valid && (!out_valid_reg || pop);
    assign eof_idx = 4'(cur_pos - ihexw_pkg::POS_EOF);

    // what follows the current position, or done
    always_comb
    begin
        seq_pos = cur_pos + 1'b1;
        done    = 1'b0;
        case (cur_pos)
            ihexw_pkg::POS_DATA_LO:
            begin
                if (head.trl)
                    seq_pos = ihexw_pkg::POS_SUM;
                else if (head.eof)
                    seq_pos = ihexw_pkg::POS_EOF;
                else
                    done = 1'b1;
            end
            ihexw_pkg::POS_NEWLINE:
            begin
                if (head.eof)
                    seq_pos = ihexw_pkg::POS_EOF;
                else
                    done = 1'b1;
            end
            ihexw_pkg::POS_EOF_LAST: done = 1'b1;
            default: ;
        endcase
    end

    always_comb
    begin
        case (cur_pos)
            5'd0:    chr = ihexw_pkg::CHAR_COLON;
            5'd1:    chr = ihexw_pkg::hex_char(head.len[7:4]);
            5'd2:    chr = ihexw_pkg::hex_char(head.len[3:0]);
            5'd3:    chr = ihexw_pkg::hex_char(head.addr[15:12]);
            5'd4:    chr = ihexw_pkg::hex_char(head.addr[11:8]);
            5'd5:    chr = ihexw_pkg::hex_char(head.addr[7:4]);
            5'd6:    chr = ihexw_pkg::hex_char(head.addr[3:0]);
            5'd7:    chr = ihexw_pkg::CHAR_ZERO;
            5'd8:    chr = ihexw_pkg::CHAR_ZERO;
            5'd9:    chr = ihexw_pkg::hex_char(head.data[7:4]);
            5'd10:   chr = ihexw_pkg::hex_char(head.data[3:0]);
            5'd11:   chr = ihexw_pkg::hex_char(head.chk[7:4]);
            5'd12:   chr = ihexw_pkg::hex_char(head.chk[3:0]);
            5'd13:   chr = ihexw_pkg::CHAR_NEWLINE;
            default: chr = (cur_pos <= ihexw_pkg::POS_EOF_LAST) ?
                           ihexw_pkg::EOF_TEXT[eof_idx] : ihexw_pkg::CHAR_NEWLINE;
        endcase
    end

    always_comb
    begin
        active_next    = active_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        text_next      = text_reg;
        last_next      = last_reg;
        q_rd           = 1'b0;
        if (step)
        begin
            out_valid_next = 1'b1;
            text_next      = chr;
            last_next      = done;
            active_next    = !done;
            pos_next       = seq_pos;
            q_rd           = done;
        end
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        text_reg <= text_next;
        last_reg <= last_next;
    end

    assign empty     = !out_valid_reg;
    assign text_char = text_reg;
    assign run_last  = last_reg;

endmodule

@@ hw/rtl/ihexw_checker.sv @@
// Port-level checks for intel_hex_record_writer_core, bound to the top level.
// Depends on intel_hex_record_writer_core_assert.svh.
`include "intel_hex_record_writer_core_assert.svh"

module ihexw_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       empty,
    input  logic       pop,
    input  logic [7:0] text_char,
    input  logic       run_last
);

    logic hex_ok;

    assign hex_ok = (text_char >= 8'h30 && text_char <= 8'h39) ||
                    (text_char >= 8'h41 && text_char <= 8'h46) ||
                    (text_char == 8'h3A) || (text_char == 8'h0A);

    // a waiting character stays until taken
    `IHEXW_ASSERT_NXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(text_char) && $stable(run_last))
    // only upper-case hex digits, colon and newline appear
    `IHEXW_ASSERT_IMP(a_charset, clk, rst_n, !empty, hex_ok)
    // a record never ends on its colon
    `IHEXW_ASSERT_IMP(a_colon_not_last, clk, rst_n, !empty && text_char == 8'h3A, !run_last)
    // a colon is followed by the high digit of the byte count, 0 or 1
    `IHEXW_ASSERT_NXT(a_after_colon, clk, rst_n, !empty && pop && text_char == 8'h3A, empty || text_char == 8'h30 || text_char == 8'h31)

endmodule

bind intel_hex_record_writer_core ihexw_checker u_ihexw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .text_char (text_char),
    .run_last  (run_last)
);
